// File: rtl/ccc_pkg.sv
// shared constants, types and helpers for the c comment/code byte counter
package ccc_pkg;

  localparam int COUNT_WIDTH = 40;
  localparam int LINE_WIDTH  = 32;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [LINE_WIDTH-1:0]  line_t;
  typedef logic [1:0]             count_inc_t;

  typedef enum logic [1:0] {
    MODE_CODE  = 2'd0,
    MODE_LINE  = 2'd1,
    MODE_BLOCK = 2'd2,
    MODE_QUOTE = 2'd3
  } lexer_mode_t;

  // held byte: slash in code, star in block, backslash in line or quote,
  // backslash then cr in line comment
  typedef enum logic [1:0] {
    HELD_NONE = 2'd0,
    HELD_ONE  = 2'd1,
    HELD_CR   = 2'd2
  } held_t;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

  function automatic count_t count_sat_add(input count_t v, input count_inc_t n);
    logic [COUNT_WIDTH:0] sum;
    sum = {1'b0, v} + (COUNT_WIDTH+1)'(n);
    return sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
  endfunction

endpackage

// File: rtl/c_comment_code_char_counter_unit.sv
// c comment/code byte counter: lexer mode tracking and saturating totals
// Takes one byte of C source per cycle (in_valid/in_ready) and returns one
// result per byte (out_valid/out_ready) in the cycle after the request is taken:
// the running comment and code totals of non-whitespace bytes, a warning flag
// with the line number when a newline ends unterminated quoted text, and, for
// a request with end_of_text set, the final totals flagged by totals_final,
// after which all counts and the lexer mode return to their reset values.
// A new byte is taken every cycle as long as the result register is empty or
// is being drained in the same cycle; the mode update and the counter adds sit
// between the input port and the result register. A '/' in code is held for
// one byte, so its count shows up in the result of the following request.
module c_comment_code_char_counter_unit (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              text_byte,
  input  logic                    end_of_text,
  output logic                    out_valid,
  input  logic                    out_ready,
  output ccc_pkg::count_t         comment_chars,
  output ccc_pkg::count_t         code_chars,
  output logic                    newline_in_quote,
  output ccc_pkg::line_t          warning_line,
  output logic                    totals_final
);
  import ccc_pkg::*;

  lexer_mode_t mode, mode_next;
  held_t       held, held_next;
  logic        quote_single, quote_single_next;
  count_t      comment_total, comment_total_next;
  count_t      code_total, code_total_next;
  line_t       line_count, line_count_next;

  count_inc_t  code_inc, comment_inc;
  logic        warn;
  logic        nb;
  logic        accept;
  logic [7:0]  quote_char;
  logic [LINE_WIDTH:0] line_sum;

  assign in_ready   = ~out_valid | out_ready;
  assign accept     = in_valid & in_ready;
  assign nb         = ~is_blank(text_byte);
  assign quote_char = quote_single ? CH_SQUOTE : CH_DQUOTE;

  // next lexer state
  always_comb begin
    mode_next         = mode;
    held_next         = held;
    quote_single_next = quote_single;
    if (!end_of_text) begin
      unique case (mode)
        MODE_CODE: begin
          if ((held != HELD_NONE) && ((text_byte == CH_SLASH) || (text_byte == CH_STAR))) begin
            held_next = HELD_NONE;
            mode_next = (text_byte == CH_SLASH) ? MODE_LINE : MODE_BLOCK;
          end else if (text_byte == CH_SLASH) begin
            held_next = HELD_ONE;
          end else begin
            held_next = HELD_NONE;
            if ((text_byte == CH_DQUOTE) || (text_byte == CH_SQUOTE)) begin
              mode_next         = MODE_QUOTE;
              quote_single_next = (text_byte == CH_SQUOTE);
            end
          end
        end
        MODE_LINE: begin
          priority if (text_byte == CH_LF) begin
            if (held == HELD_NONE) mode_next = MODE_CODE;
            held_next = HELD_NONE;
          end else if (text_byte == CH_BSLASH) begin
            held_next = HELD_ONE;
          end else if ((text_byte == CH_CR) && (held == HELD_ONE)) begin
            held_next = HELD_CR;
          end else begin
            held_next = HELD_NONE;
          end
        end
        MODE_BLOCK: begin
          if ((held != HELD_NONE) && (text_byte == CH_SLASH)) begin
            mode_next = MODE_CODE;
            held_next = HELD_NONE;
          end else begin
            held_next = (text_byte == CH_STAR) ? HELD_ONE : HELD_NONE;
          end
        end
        MODE_QUOTE: begin
          priority if (held != HELD_NONE) begin
            held_next = HELD_NONE;
          end else if (text_byte == CH_BSLASH) begin
            held_next = HELD_ONE;
          end else if ((text_byte == quote_char) || (text_byte == CH_LF)) begin
            mode_next = MODE_CODE;
          end else begin
            held_next = HELD_NONE;
          end
        end
      endcase
    end
  end

  // counter increments and warning
  always_comb begin
    code_inc    = '0;
    comment_inc = '0;
    warn        = 1'b0;
    if (end_of_text) begin
      if ((mode == MODE_CODE) && (held != HELD_NONE)) code_inc = 2'd1;
    end else begin
      unique case (mode)
        MODE_CODE: begin
          if ((held != HELD_NONE) && ((text_byte == CH_SLASH) || (text_byte == CH_STAR))) begin
            comment_inc = 2'd2;
          end else begin
            // held slash goes to code, then this byte if it is non-blank and not a new slash
            code_inc = 2'((held != HELD_NONE) ? 1 : 0)
                     + 2'(((text_byte != CH_SLASH) && nb) ? 1 : 0);
          end
        end
        MODE_LINE:  comment_inc = 2'(nb);
        MODE_BLOCK: comment_inc = 2'(nb);
        MODE_QUOTE: begin
          if ((held == HELD_NONE) && (text_byte == CH_LF) && (text_byte != quote_char)) begin
            warn = 1'b1;
          end else begin
            code_inc = 2'(nb);
          end
        end
      endcase
    end
  end

  assign comment_total_next = count_sat_add(comment_total, comment_inc);
  assign code_total_next    = count_sat_add(code_total, code_inc);
  assign line_sum           = {1'b0, line_count} + (LINE_WIDTH+1)'(1);
  assign line_count_next    = (text_byte != CH_LF) ? line_count :
                              (line_sum[LINE_WIDTH] ? '1 : line_sum[LINE_WIDTH-1:0]);

  // lexer state and totals
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_CODE;
      held          <= HELD_NONE;
      quote_single  <= 1'b0;
      comment_total <= '0;
      code_total    <= '0;
      line_count    <= LINE_WIDTH'(1);
    end else if (accept) begin
      if (end_of_text) begin
        mode          <= MODE_CODE;
        held          <= HELD_NONE;
        quote_single  <= 1'b0;
        comment_total <= '0;
        code_total    <= '0;
        line_count    <= LINE_WIDTH'(1);
      end else begin
        mode          <= mode_next;
        held          <= held_next;
        quote_single  <= quote_single_next;
        comment_total <= comment_total_next;
        code_total    <= code_total_next;
        line_count    <= line_count_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      comment_chars    <= comment_total_next;
      code_chars       <= code_total_next;
      newline_in_quote <= warn;
      warning_line     <= line_count;
      totals_final     <= end_of_text;
    end
  end

  a_eot_clears: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_text |=> (mode == MODE_CODE) && (held == HELD_NONE)
      && (comment_total == '0) && (code_total == '0) && (line_count == LINE_WIDTH'(1)))
    else $error("state not cleared after end of text");

  a_cr_only_in_line: assert property (@(posedge clk) disable iff (rst)
    (held == HELD_CR) |-> (mode == MODE_LINE))
    else $error("backslash-cr hold outside line comment");

  a_warn_not_final: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(newline_in_quote && totals_final))
    else $error("warning on end-of-text result");

  a_warn_source: assert property (@(posedge clk) disable iff (rst)
    accept && !end_of_text |=> newline_in_quote == (($past(mode) == MODE_QUOTE)
      && ($past(held) == HELD_NONE) && ($past(text_byte) == CH_LF)))
    else $error("quote warning does not match lexer state");

  a_line_monotonic: assert property (@(posedge clk) disable iff (rst)
    accept && !end_of_text |=> line_count >= $past(line_count))
    else $error("line count went backwards");

endmodule

// File: test/c_comment_code_char_counter_unit_tb.sv
// testbench for the c comment/code byte counter: directed and random c-like text against a local predictor
module c_comment_code_char_counter_unit_tb;
  import ccc_pkg::*;

  localparam int unsigned TEXT_ITEMS  = 1500;
  localparam int unsigned CYCLE_LIMIT = 300000;

  typedef struct packed {
    logic [7:0] text;
    logic       eot;
    logic       drain;
  } char_req_t;

  typedef struct packed {
    count_t comment_n;
    count_t code_n;
    logic   warn;
    line_t  line_at;
    logic   is_total;
  } tally_t;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_COIN,
    READY_SPARSE,
    READY_MASK
  } ready_style_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] text_byte = 8'h00;
  logic       end_of_text = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  count_t     comment_chars;
  count_t     code_chars;
  logic       newline_in_quote;
  line_t      warning_line;
  logic       totals_final;

  char_req_t    pending_chars[$];
  tally_t       predicted_tallies[$];
  int unsigned  chars_taken = 0;
  int unsigned  chars_checked = 0;
  int unsigned  cycle_count = 0;
  logic         failed = 1'b0;
  logic         drain_pending = 1'b0;

  int unsigned  burst_left = 0;
  int unsigned  gap_left = 0;
  ready_style_t ready_style = READY_ALWAYS;
  int unsigned  style_left = 0;
  logic [7:0]   ready_mask = 8'hFF;
  int unsigned  holdoff_left = 0;
  int unsigned  holdoff_at = 250;

  lexer_mode_t  lx_mode;
  logic         lx_single;
  held_t        lx_held;
  count_t       comment_sum;
  count_t       code_sum;
  line_t        line_no;

  c_comment_code_char_counter_unit u_top (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic blank(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == 8'h0B) ||
           (b == 8'h0C) || (b == CH_CR);
  endfunction

  function automatic count_t bump(input count_t v, input int unsigned n);
    count_t ceiling;
    ceiling = '1;
    return (ceiling - v < count_t'(n)) ? ceiling : v + count_t'(n);
  endfunction

  function automatic void clear_lexer();
    lx_mode     = MODE_CODE;
    lx_single   = 1'b0;
    lx_held     = HELD_NONE;
    comment_sum = '0;
    code_sum    = '0;
    line_no     = line_t'(1);
  endfunction

  function automatic void add_code(input logic [7:0] b);
    if (!blank(b)) code_sum = bump(code_sum, 1);
  endfunction

  function automatic void add_comment(input logic [7:0] b);
    if (!blank(b)) comment_sum = bump(comment_sum, 1);
  endfunction

  function automatic void code_take(input logic [7:0] b);
    if (b == CH_SLASH) begin
      lx_held = HELD_ONE;
    end else begin
      add_code(b);
      if (b == CH_DQUOTE || b == CH_SQUOTE) begin
        lx_mode   = MODE_QUOTE;
        lx_single = (b == CH_SQUOTE);
      end
    end
  endfunction

  function automatic tally_t predict_char(input logic [7:0] b, input logic eot);
    tally_t r;
    line_t  line_now;
    logic   warn;
    line_now = line_no;
    warn     = 1'b0;
    if (eot) begin
      if (lx_mode == MODE_CODE && lx_held == HELD_ONE) add_code(CH_SLASH);
      r.comment_n = comment_sum;
      r.code_n    = code_sum;
      r.warn      = 1'b0;
      r.line_at   = line_now;
      r.is_total  = 1'b1;
      clear_lexer();
      return r;
    end
    case (lx_mode)
      MODE_CODE: begin
        if (lx_held != HELD_NONE) begin
          lx_held = HELD_NONE;
          if (b == CH_SLASH || b == CH_STAR) begin
            comment_sum = bump(comment_sum, 2);
            lx_mode = (b == CH_SLASH) ? MODE_LINE : MODE_BLOCK;
          end else begin
            add_code(CH_SLASH);
            code_take(b);
          end
        end else begin
          code_take(b);
        end
      end
      MODE_LINE: begin
        add_comment(b);
        if (b == CH_LF) begin
          if (lx_held == HELD_NONE) lx_mode = MODE_CODE;
          lx_held = HELD_NONE;
        end else if (b == CH_BSLASH) begin
          lx_held = HELD_ONE;
        end else if (b == CH_CR && lx_held == HELD_ONE) begin
          lx_held = HELD_CR;
        end else begin
          lx_held = HELD_NONE;
        end
      end
      MODE_BLOCK: begin
        add_comment(b);
        if (lx_held != HELD_NONE && b == CH_SLASH) begin
          lx_mode = MODE_CODE;
          lx_held = HELD_NONE;
        end else begin
          lx_held = (b == CH_STAR) ? HELD_ONE : HELD_NONE;
        end
      end
      MODE_QUOTE: begin
        if (lx_held != HELD_NONE) begin
          add_code(b);
          lx_held = HELD_NONE;
        end else if (b == CH_BSLASH) begin
          add_code(b);
          lx_held = HELD_ONE;
        end else if (b == (lx_single ? CH_SQUOTE : CH_DQUOTE)) begin
          add_code(b);
          lx_mode = MODE_CODE;
        end else if (b == CH_LF) begin
          warn    = 1'b1;
          lx_mode = MODE_CODE;
        end else begin
          add_code(b);
        end
      end
    endcase
    if (b == CH_LF && line_no != '1) line_no = line_no + line_t'(1);
    r.comment_n = comment_sum;
    r.code_n    = code_sum;
    r.warn      = warn;
    r.line_at   = line_now;
    r.is_total  = 1'b0;
    return r;
  endfunction

  task automatic queue_item(input logic [7:0] b, input logic eot);
    char_req_t req;
    req.text  = b;
    req.eot   = eot;
    req.drain = drain_pending;
    pending_chars.push_back(req);
    drain_pending = 1'b0;
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_item(8'(s[i]), 1'b0);
  endtask

  function automatic logic [7:0] pick_code_char();
    string set;
    set = "abcxyz_019+-=;(){}[]<>&|!,.#% \t";
    return 8'(set[$urandom_range(0, set.len() - 1)]);
  endfunction

  function automatic logic [7:0] pick_text_char();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return 8'($urandom_range(8'h80, 8'hFF));
    if (roll == 1) return CH_TAB;
    if (roll == 2) return CH_SPACE;
    if (roll == 3) return 8'($urandom_range(8'h00, 8'h1F));
    return 8'($urandom_range(8'h21, 8'h7E));
  endfunction

  task automatic queue_random_token();
    int unsigned kind;
    int unsigned n;
    logic [7:0]  q;
    logic [7:0]  c;
    kind = $urandom_range(0, 99);
    n    = $urandom_range(0, 12);
    if (kind < 30) begin
      for (int i = 0; i <= n % 8; i++) queue_item(pick_code_char(), 1'b0);
    end else if (kind < 40) begin
      if ($urandom_range(0, 2) == 0) queue_item(CH_CR, 1'b0);
      queue_item(CH_LF, 1'b0);
    end else if (kind < 52) begin
      queue_text("//");
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 9))
          0: queue_text("\\\n");
          1: queue_text("\\\r\n");
          default: queue_item(pick_text_char(), 1'b0);
        endcase
      end
      queue_item(CH_LF, 1'b0);
    end else if (kind < 64) begin
      queue_text(($urandom_range(0, 9) == 0) ? "/*/" : "/*");
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 9))
          0, 1: queue_item(CH_STAR, 1'b0);
          2: queue_item(CH_LF, 1'b0);
          default: queue_item(pick_text_char(), 1'b0);
        endcase
      end
      queue_text("*/");
    end else if (kind < 78) begin
      q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
      queue_item(q, 1'b0);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 9))
          0, 1: begin
            queue_item(CH_BSLASH, 1'b0);
            case ($urandom_range(0, 3))
              0: queue_item(CH_LF, 1'b0);
              1: queue_item(q, 1'b0);
              2: queue_item(CH_BSLASH, 1'b0);
              default: queue_item(8'($urandom_range(0, 255)), 1'b0);
            endcase
          end
          default: begin
            c = pick_text_char();
            if (c == q || c == CH_BSLASH || c == CH_LF) c = 8'h61;
            queue_item(c, 1'b0);
          end
        endcase
      end
      queue_item(($urandom_range(0, 4) == 0) ? CH_LF : q, 1'b0);
    end else if (kind < 84) begin
      queue_item(CH_SLASH, 1'b0);
      queue_item(pick_code_char(), 1'b0);
    end else if (kind < 98) begin
      for (int i = 0; i <= n % 3; i++) queue_item(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      queue_item(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  always @(posedge clk) begin : drive_chars
    logic        fire;
    logic        offer;
    int unsigned taken_now;
    fire      = in_valid && in_ready;
    offer     = 1'b0;
    taken_now = chars_taken + (fire ? 1 : 0);
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (fire) begin
        predicted_tallies.push_back(predict_char(text_byte, end_of_text));
        pending_chars.delete(0);
        chars_taken <= taken_now;
      end
      if (!in_valid || fire) begin
        if (gap_left != 0) begin
          gap_left = gap_left - 1;
        end else if (pending_chars.size() != 0 &&
                     !(pending_chars[0].drain && taken_now != chars_checked)) begin
          offer = 1'b1;
          if (burst_left == 0)
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
          burst_left = burst_left - 1;
          if (burst_left == 0) gap_left = $urandom_range(1, 6);
        end
        in_valid <= offer;
        if (offer) begin
          text_byte   <= pending_chars[0].text;
          end_of_text <= pending_chars[0].eot;
        end
      end
    end
  end

  function automatic void flag_field(input string name, input logic [63:0] want,
                                     input logic [63:0] got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    failed = 1'b1;
  endfunction

  always @(posedge clk) begin : check_tallies
    tally_t want;
    logic   next_ready;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        chars_checked <= chars_checked + 1;
        if (predicted_tallies.size() == 0) begin
          $display("%0t: result with nothing expected", $time);
          failed = 1'b1;
        end else begin
          want = predicted_tallies.pop_front();
          if (comment_chars !== want.comment_n)
            flag_field("comment_chars", 64'(want.comment_n), 64'(comment_chars));
          if (code_chars !== want.code_n)
            flag_field("code_chars", 64'(want.code_n), 64'(code_chars));
          if (newline_in_quote !== want.warn)
            flag_field("newline_in_quote", 64'(want.warn), 64'(newline_in_quote));
          if (warning_line !== want.line_at)
            flag_field("warning_line", 64'(want.line_at), 64'(warning_line));
          if (totals_final !== want.is_total)
            flag_field("totals_final", 64'(want.is_total), 64'(totals_final));
        end
      end
      // long hold-off so the block backs up into its input
      if (holdoff_left != 0) begin
        holdoff_left = holdoff_left - 1;
        next_ready   = 1'b0;
      end else if (chars_checked >= holdoff_at) begin
        holdoff_left = 200;
        holdoff_at   = holdoff_at + 700;
        next_ready   = 1'b0;
      end else begin
        if (style_left == 0) begin
          ready_style = ready_style_t'($urandom_range(0, 3));
          style_left  = $urandom_range(20, 200);
          ready_mask  = 8'($urandom_range(0, 255)) | 8'h01;
        end else begin
          style_left = style_left - 1;
        end
        case (ready_style)
          READY_ALWAYS: next_ready = 1'b1;
          READY_COIN:   next_ready = 1'($urandom_range(0, 1));
          READY_SPARSE: next_ready = ($urandom_range(0, 3) == 0);
          default: begin
            next_ready = ready_mask[0];
            ready_mask = {ready_mask[0], ready_mask[7:1]};
          end
        endcase
      end
      out_ready <= next_ready;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("c_comment_code_char_counter_unit regression: fail");
      $finish;
    end
  end

  initial begin
    int unsigned drain_mark;
    drain_mark = 400;
    clear_lexer();

    queue_item(8'h00, 1'b0);
    queue_item(CH_SLASH, 1'b0);
    queue_item(8'hFF, 1'b0);
    queue_text("//\\\nx\\\r\ny\n");
    queue_text("\"\\\n\n");
    queue_text("'a'");
    queue_text("/*/*/");
    queue_item(CH_SLASH, 1'b0);
    queue_item(8'($urandom_range(0, 255)), 1'b1);
    queue_text("/a");

    drain_pending = 1'b1;
    while (pending_chars.size() < TEXT_ITEMS) begin
      if (pending_chars.size() >= drain_mark) begin
        drain_pending = 1'b1;
        drain_mark    = drain_mark + 400;
      end
      queue_random_token();
    end
    queue_item(8'($urandom_range(0, 255)), 1'b1);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (pending_chars.size() != 0 || in_valid || chars_taken != chars_checked)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (predicted_tallies.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, predicted_tallies.size());
      failed = 1'b1;
    end
    if (!failed) begin
      $display("c_comment_code_char_counter_unit regression: pass");
    end else begin
      $display("c_comment_code_char_counter_unit regression: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/ccc_pkg.sv
rtl/c_comment_code_char_counter_unit.sv
test/c_comment_code_char_counter_unit_tb.sv
